[design/tccs_pkg.sv]
// Package for the text console cursor/scroll unit.
// Holds geometry defaults, character codes, register indexes, FSM state and
// the command/status structs shared by the controller and the datapath.
package tccs_pkg;

    localparam int TCCS_COLUMNS = 80;
    localparam int TCCS_ROWS    = 25;

    localparam logic [7:0] CODE_NEWLINE   = 8'h0D;
    localparam logic [7:0] CODE_BACKSPACE = 8'h08;

    localparam logic [7:0] RST_TEXT_ATTR   = 8'h0A;
    localparam logic [7:0] RST_CURSOR_GLYPH = 8'd95;
    localparam logic [7:0] RST_CURSOR_ATTR  = 8'hDA;

    localparam logic [1:0] CFG_TEXT_ATTR    = 2'd0;
    localparam logic [1:0] CFG_CURSOR_GLYPH = 2'd1;
    localparam logic [1:0] CFG_CURSOR_ATTR  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCROLL,
        S_DRAW,
        S_READ_DONE
    } t_state;

    typedef struct packed {
        logic clear_step;   // clear one memory entry of the power-up sweep
        logic accept;       // an input item is taken this cycle
        logic scroll_step;  // one step of the bottom-row copy
        logic draw;         // draw the cursor cell and load a put result
        logic load_read;    // load a read result
    } t_cmd;

    typedef struct packed {
        logic clear_last;   // last entry of the power-up sweep
        logic req_read;     // offered item is a read request
        logic scroll_now;   // offered put item moves past the last row
        logic scroll_last;  // bottom-row copy finishes this cycle
        logic out_free;     // output register can take a result
    } t_status;

endpackage

[design/text_console_cursor_scroll_unit.sv]
// Top level of the text console cursor/scroll unit.
// Depends on tccs_pkg, tccs_ctrl and tccs_datapath.
//
// Text console over a ROWS x COLUMNS screen of 16-bit cells (character in
// the low byte, attribute in the high byte) held in one memory with one
// write and one registered read port. After reset a clearing pass writes
// zero to every cell, during which no item is taken; configuration writes
// are taken at any time. For a put that stays on screen the old cursor
// cell is written as the item is taken and the new cursor cell in the
// draw state once the output register is free. For a put that moves past
// the last row, rows are addressed through a rotating base, so a scroll
// only walks one row through the memory ports before the draw, copying
// the attributes of the bottom row with blank characters. One item is in
// work at a time; a finished result waits in the output register while
// the next item is taken.
module text_console_cursor_scroll_unit #(
    parameter int COLUMNS = tccs_pkg::TCCS_COLUMNS,
    parameter int ROWS    = tccs_pkg::TCCS_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // char_code[7:0], cell_row[12:8], cell_col[19:13], 0
    input  logic [0:0]  s_axis_tuser,  // req_type[0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // cell_char[7:0], cell_attr[15:8],
                                       // cursor_row[20:16], cursor_col[27:21], 0
);
    import tccs_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    tccs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tccs_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cmd         (cmd),
        .o_status      (status)
    );

endmodule

[design/tccs_ctrl.sv]
// Controller FSM of the text console unit.
// Depends on tccs_pkg for the state enum and the command/status structs.
module tccs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tccs_pkg::t_status i_status,
    output tccs_pkg::t_cmd    o_cmd
);
    import tccs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.req_read) begin
                        n_state = S_READ_DONE;
                    end else if (i_status.scroll_now) begin
                        n_state = S_SCROLL;
                    end else begin
                        n_state = S_DRAW;
                    end
                end
            end
            S_SCROLL: begin
                if (i_status.scroll_last) n_state = S_DRAW;
            end
            S_DRAW: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_READ_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_SCROLL: begin
                o_cmd.scroll_step = 1'b1;
            end
            S_DRAW: begin
                o_cmd.draw = i_status.out_free;
            end
            S_READ_DONE: begin
                o_cmd.load_read = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[design/tccs_datapath.sv]
// Datapath of the text console unit: screen memory, cursor, row base,
// configuration registers and the output register.
// Depends on tccs_pkg; driven by tccs_ctrl through t_cmd / t_status.
module tccs_datapath #(
    parameter int COLUMNS = tccs_pkg::TCCS_COLUMNS,
    parameter int ROWS    = tccs_pkg::TCCS_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic [23:0]       s_axis_tdata,
    input  logic [0:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,
    input  tccs_pkg::t_cmd    i_cmd,
    output tccs_pkg::t_status o_status
);
    import tccs_pkg::*;

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = CW + 1;

    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [RW:0]   ROWS_EXT  = (RW + 1)'(ROWS);
    localparam logic [AW-1:0] COLS_ADDR = AW'(COLUMNS);
    localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
    localparam logic [SW-1:0] SCR_END   = SW'(COLUMNS);
    localparam logic [31:0]   ROWS_W    = 32'(ROWS);
    localparam logic [31:0]   COLS_W    = 32'(COLUMNS);

    // Logical row plus base, folded once, gives the physical row.
    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] lrow,
                                                input logic [CW-1:0] col,
                                                input logic [RW-1:0] base);
        logic [RW:0]   sum;
        logic [RW-1:0] prow;
        sum = {1'b0, lrow} + {1'b0, base};
        if (sum >= ROWS_EXT) sum = sum - ROWS_EXT;
        prow = sum[RW-1:0];
        return AW'(prow) * COLS_ADDR + AW'(col);
    endfunction

    logic [15:0]   r_mem [DEPTH];
    logic [15:0]   r_rd_data;
    logic          r_read_oob;
    logic [7:0]    r_text_attr;
    logic [7:0]    r_cursor_glyph;
    logic [7:0]    r_cursor_attr;
    logic [RW-1:0] r_cur_row;
    logic [CW-1:0] r_cur_col;
    logic [RW-1:0] r_base;
    logic [AW-1:0] r_clr_cnt;
    logic [SW-1:0] r_scr_cnt;
    logic          r_out_valid;
    logic [31:0]   r_out_data;

    logic [RW-1:0] n_cur_row;
    logic [CW-1:0] n_cur_col;

    logic [7:0]    in_code;
    logic [4:0]    in_row;
    logic [6:0]    in_col;
    logic          in_read;
    logic [31:0]   in_row32;
    logic [31:0]   in_col32;
    logic          in_oob;
    logic          row_inc;
    logic          scroll_now;
    logic          put_accept;
    logic [15:0]   put_data;
    logic [SW-1:0] scr_prev;
    logic [AW-1:0] cur_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   row32;
    logic [31:0]   col32;
    logic [7:0]    res_char;
    logic [7:0]    res_attr;

    assign in_code    = s_axis_tdata[7:0];
    assign in_row     = s_axis_tdata[12:8];
    assign in_col     = s_axis_tdata[19:13];
    assign in_read    = s_axis_tuser[0];
    assign in_row32   = 32'(in_row);
    assign in_col32   = 32'(in_col);
    assign in_oob     = (in_row32 >= ROWS_W) || (in_col32 >= COLS_W);
    assign put_accept = i_cmd.accept && !in_read;
    assign scr_prev   = r_scr_cnt - 1'b1;
    assign cur_addr   = cell_addr(r_cur_row, r_cur_col, r_base);

    // Newline and backspace blank the old cell; other codes print there.
    assign put_data = ((in_code == CODE_NEWLINE) || (in_code == CODE_BACKSPACE))
                      ? 16'h0000 : {r_text_attr, in_code};

    always_comb begin
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        row_inc   = 1'b0;
        if (in_code == CODE_NEWLINE) begin
            n_cur_col = '0;
            row_inc   = 1'b1;
        end else if (in_code == CODE_BACKSPACE) begin
            if (r_cur_col == '0) begin
                // wrap to the row above; hold at the origin
                if (r_cur_row != '0) begin
                    n_cur_col = COL_LAST;
                    n_cur_row = r_cur_row - 1'b1;
                end
            end else begin
                n_cur_col = r_cur_col - 1'b1;
            end
        end else if (r_cur_col == COL_LAST) begin
            n_cur_col = '0;
            row_inc   = 1'b1;
        end else begin
            n_cur_col = r_cur_col + 1'b1;
        end
        scroll_now = row_inc && (r_cur_row == ROW_LAST);
        if (row_inc && !scroll_now) n_cur_row = r_cur_row + 1'b1;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_data = put_data;
        if (i_cmd.clear_step) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_cnt;
            wr_data = 16'h0000;
        end else if (put_accept) begin
            wr_en = 1'b1;
        end else if (i_cmd.scroll_step && (r_scr_cnt != '0)) begin
            // old top row becomes the bottom row: keep attributes, drop chars
            wr_en   = 1'b1;
            wr_addr = cell_addr('0, scr_prev[CW-1:0], r_base);
            wr_data = {r_rd_data[15:8], 8'h00};
        end else if (i_cmd.draw) begin
            wr_en   = 1'b1;
            wr_data = {r_cursor_attr, r_cursor_glyph};
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = cell_addr(in_row32[RW-1:0], in_col32[CW-1:0], r_base);
        if (i_cmd.accept && in_read) begin
            rd_en = 1'b1;
        end else if (i_cmd.scroll_step && (r_scr_cnt != SCR_END)) begin
            rd_en   = 1'b1;
            rd_addr = cell_addr(ROW_LAST, r_scr_cnt[CW-1:0], r_base);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt      <= '0;
            r_scr_cnt      <= '0;
            r_base         <= '0;
            r_cur_row      <= '0;
            r_cur_col      <= '0;
            r_text_attr    <= RST_TEXT_ATTR;
            r_cursor_glyph <= RST_CURSOR_GLYPH;
            r_cursor_attr  <= RST_CURSOR_ATTR;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.clear_step) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (put_accept) begin
                r_cur_row <= n_cur_row;
                r_cur_col <= n_cur_col;
            end
            if (i_cmd.scroll_step) begin
                if (r_scr_cnt == SCR_END) begin
                    r_scr_cnt <= '0;
                    r_base    <= (r_base == ROW_LAST) ? '0 : r_base + 1'b1;
                end else begin
                    r_scr_cnt <= r_scr_cnt + 1'b1;
                end
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TEXT_ATTR:    r_text_attr    <= i_cfg_data;
                    CFG_CURSOR_GLYPH: r_cursor_glyph <= i_cfg_data;
                    CFG_CURSOR_ATTR:  r_cursor_attr  <= i_cfg_data;
                    default: begin
                        r_text_attr <= r_text_attr;
                    end
                endcase
            end
            if (i_cmd.draw || i_cmd.load_read) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign row32    = 32'(r_cur_row);
    assign col32    = 32'(r_cur_col);
    assign res_char = (i_cmd.load_read && !r_read_oob) ? r_rd_data[7:0]  : 8'h00;
    assign res_attr = (i_cmd.load_read && !r_read_oob) ? r_rd_data[15:8] : 8'h00;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_read_oob <= in_oob;
        if (i_cmd.draw || i_cmd.load_read) begin
            r_out_data <= {4'b0000, col32[6:0], row32[4:0], res_attr, res_char};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign o_status.clear_last  = (r_clr_cnt == ADDR_LAST);
    assign o_status.req_read    = in_read;
    assign o_status.scroll_now  = scroll_now;
    assign o_status.scroll_last = (r_scr_cnt == SCR_END);
    assign o_status.out_free    = !r_out_valid || m_axis_tready;

endmodule

[design/tccs_checker.sv]
// Port-level checker for the text console unit, bound to the top level.
// Depends on the top level's ports and geometry parameters, and on tccs_pkg for their defaults.
module tccs_checker #(
    parameter int COLUMNS = tccs_pkg::TCCS_COLUMNS,
    parameter int ROWS    = tccs_pkg::TCCS_ROWS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    localparam logic [31:0] COLS_W = 32'(COLUMNS);
    localparam logic [31:0] ROWS_W = 32'(ROWS);

    // One item in work: taking an item closes the input for the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // A new result only follows a cycle in which the input was closed.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without an item in work");

    // Reported cursor stays on the screen.
    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (({25'b0, m_axis_tdata[27:21]} < COLS_W)
                       && (({27'b0, m_axis_tdata[20:16]} < ROWS_W) || (ROWS > 32))))
        else $error("cursor outside the screen");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result dropped or changed");

endmodule

bind text_console_cursor_scroll_unit tccs_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccs_checker (.*);
